>>> hdl/jeq_pkg.sv
// ----------------------------------------------------------------------------
// jeq_pkg
// Shared types and codes of the joystick event qualifier.
// ----------------------------------------------------------------------------
package jeq_pkg;

    localparam int CENTER_W = 12;
    localparam int DEAD_W   = 11;
    localparam int HYST_W   = 10;
    localparam int MS_W     = 16;
    localparam int IDX_W    = 3;
    localparam int DATA_W   = 16;
    localparam int CODE_W   = 3;

    localparam logic [CENTER_W-1:0] CENTER_RST    = 12'd2048;
    localparam logic [DEAD_W-1:0]   DEAD_RST      = 11'd500;
    localparam logic [HYST_W-1:0]   HYST_RST      = 10'd150;
    localparam logic [MS_W-1:0]     LONG_RST      = 16'd1000;
    localparam logic [MS_W-1:0]     LOCKOUT_RST   = 16'd300;
    localparam logic [MS_W-1:0]     INIT_DLY_RST  = 16'd500;
    localparam logic [MS_W-1:0]     REPEAT_RST    = 16'd150;

    typedef enum logic [CODE_W-1:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_RIGHT = 3'd3,
        DIR_LEFT  = 3'd4
    } dir_t;

    localparam logic [CODE_W-1:0] EV_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] EV_SHORT = 3'd3;
    localparam logic [CODE_W-1:0] EV_LONG  = 3'd5;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_LOCK   = 2'd1,
        OP_TAKE   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    localparam logic [IDX_W-1:0] REG_CENTER    = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEAD      = 3'd1;
    localparam logic [IDX_W-1:0] REG_HYST      = 3'd2;
    localparam logic [IDX_W-1:0] REG_LONG      = 3'd3;
    localparam logic [IDX_W-1:0] REG_LOCKOUT   = 3'd4;
    localparam logic [IDX_W-1:0] REG_INIT_DLY  = 3'd5;
    localparam logic [IDX_W-1:0] REG_REPEAT    = 3'd6;
    localparam logic [IDX_W-1:0] REG_BTN_IGN   = 3'd7;

    typedef struct packed {
        logic [CENTER_W-1:0] center;
        logic [DEAD_W-1:0]   dead;
        logic [HYST_W-1:0]   hyst;
    } zone_cfg_t;

endpackage

>>> hdl/jeq_classify.sv
// ----------------------------------------------------------------------------
// jeq_classify
// Picks the dominant axis and applies dead zone and hysteresis thresholds.
// ----------------------------------------------------------------------------
module jeq_classify #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic [SAMPLE_BITS-1:0] x_sample,
    input  logic [SAMPLE_BITS-1:0] y_sample,
    input  jeq_pkg::zone_cfg_t     zone,
    input  jeq_pkg::dir_t          held,
    output jeq_pkg::dir_t          dir
);

    localparam int CW = SAMPLE_BITS + 6;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] hold_hi;
    logic signed [CW-1:0] hold_lo;
    logic signed [CW-1:0] enter_hi;
    logic signed [CW-1:0] enter_lo;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;

    always_comb
    begin
        xs       = $signed(CW'(x_sample));
        ys       = $signed(CW'(y_sample));
        c        = $signed(CW'(zone.center));
        dx       = (xs > c) ? xs - c : c - xs;
        dy       = (ys > c) ? ys - c : c - ys;
        hold_hi  = c + $signed(CW'(zone.dead));
        hold_lo  = c - $signed(CW'(zone.dead));
        enter_hi = hold_hi + $signed(CW'(zone.hyst));
        enter_lo = hold_lo - $signed(CW'(zone.hyst));
        dir      = jeq_pkg::DIR_NONE;
        if (dx > dy)
        begin
            hi = (held == jeq_pkg::DIR_RIGHT) ? hold_hi : enter_hi;
            lo = (held == jeq_pkg::DIR_LEFT)  ? hold_lo : enter_lo;
            if (xs > hi)
                dir = jeq_pkg::DIR_RIGHT;
            else if (xs < lo)
                dir = jeq_pkg::DIR_LEFT;
        end
        else
        begin
            lo = (held == jeq_pkg::DIR_UP)   ? hold_lo : enter_lo;
            hi = (held == jeq_pkg::DIR_DOWN) ? hold_hi : enter_hi;
            if (ys < lo)
                dir = jeq_pkg::DIR_UP;
            else if (ys > hi)
                dir = jeq_pkg::DIR_DOWN;
        end
    end

endmodule

>>> hdl/joystick_event_qualifier.sv
// ----------------------------------------------------------------------------
// joystick_event_qualifier
// Turns joystick axis samples and a button level into menu events. One word
// is accepted per clock unless the input stalls: it is captured in an input
// register and processed from there, where the state updates and a take word
// loads the result register. The only source of input stall is a take word
// waiting in the input register while the result register still holds an
// untaken word; a sample or lock word never stalls by itself but waits behind
// such a take. All timing compares wrap modulo 2^TIME_BITS.
// ----------------------------------------------------------------------------
module joystick_event_qualifier #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic [1:0]                 operation,
    input  logic [SAMPLE_BITS-1:0]     x_sample,
    input  logic [SAMPLE_BITS-1:0]     y_sample,
    input  logic                       button_level,
    input  logic [TIME_BITS-1:0]       time_ms,

    output logic                       event_valid,
    input  logic                       event_stall,
    output logic [jeq_pkg::CODE_W-1:0] event_code,
    output logic                       from_axis,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [jeq_pkg::IDX_W-1:0]  cfg_index,
    input  logic [jeq_pkg::DATA_W-1:0] cfg_data
);

    // configuration
    logic [jeq_pkg::CENTER_W-1:0] center_reg;
    logic [jeq_pkg::DEAD_W-1:0]   dead_reg;
    logic [jeq_pkg::HYST_W-1:0]   hyst_reg;
    logic [jeq_pkg::MS_W-1:0]     long_reg;
    logic [jeq_pkg::MS_W-1:0]     lockout_reg;
    logic [jeq_pkg::MS_W-1:0]     init_dly_reg;
    logic [jeq_pkg::MS_W-1:0]     repeat_reg;
    logic                         btn_ign_reg;

    // input stage
    logic                         item_vld_reg;
    jeq_pkg::op_t                 op_reg;
    logic [SAMPLE_BITS-1:0]       x_reg;
    logic [SAMPLE_BITS-1:0]       y_reg;
    logic                         btn_reg;
    logic [TIME_BITS-1:0]         time_reg;

    // event state
    jeq_pkg::dir_t                held_reg, held_next;
    logic [TIME_BITS-1:0]         dir_start_reg, dir_start_next;
    logic [TIME_BITS-1:0]         last_rep_reg, last_rep_next;
    logic                         first_done_reg, first_done_next;
    jeq_pkg::dir_t                last_os_dir_reg, last_os_dir_next;
    logic [TIME_BITS-1:0]         last_os_time_reg, last_os_time_next;
    logic                         lock_reg, lock_next;
    logic [jeq_pkg::CODE_W-1:0]   pend_axis_reg, pend_axis_next;
    logic                         btn_down_reg, btn_down_next;
    logic [TIME_BITS-1:0]         press_start_reg, press_start_next;
    logic                         long_fired_reg, long_fired_next;
    logic                         pend_long_reg, pend_long_next;
    logic                         pend_short_reg, pend_short_next;

    // result stage
    logic                         event_valid_reg;
    logic [jeq_pkg::CODE_W-1:0]   event_code_reg, event_code_next;
    logic                         from_axis_reg, from_axis_next;

    logic                         take_blocked;
    logic                         fire;
    logic                         pressed;
    logic                         repeatable;
    logic                         os_locked;
    jeq_pkg::zone_cfg_t           zone;
    jeq_pkg::dir_t                dir;

    assign zone = '{center: center_reg, dead: dead_reg, hyst: hyst_reg};

    jeq_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .x_sample (x_reg),
        .y_sample (y_reg),
        .zone     (zone),
        .held     (held_reg),
        .dir      (dir)
    );

    assign take_blocked = item_vld_reg && (op_reg == jeq_pkg::OP_TAKE)
                          && event_valid_reg && event_stall;
    assign fire         = item_vld_reg && !take_blocked;
    assign sample_stall = take_blocked;
    assign cfg_ready    = 1'b1;
    assign event_valid  = event_valid_reg;
    assign event_code   = event_code_reg;
    assign from_axis    = from_axis_reg;

    assign pressed    = !btn_reg && !btn_ign_reg;
    assign repeatable = (dir == jeq_pkg::DIR_UP) || (dir == jeq_pkg::DIR_DOWN);
    assign os_locked  = !repeatable && (dir == last_os_dir_reg)
                        && ((time_reg - last_os_time_reg) < TIME_BITS'(lockout_reg));

    always_comb
    begin
        held_next         = held_reg;
        dir_start_next    = dir_start_reg;
        last_rep_next     = last_rep_reg;
        first_done_next   = first_done_reg;
        last_os_dir_next  = last_os_dir_reg;
        last_os_time_next = last_os_time_reg;
        lock_next         = lock_reg;
        pend_axis_next    = pend_axis_reg;
        btn_down_next     = btn_down_reg;
        press_start_next  = press_start_reg;
        long_fired_next   = long_fired_reg;
        pend_long_next    = pend_long_reg;
        pend_short_next   = pend_short_reg;
        event_code_next   = jeq_pkg::EV_NONE;
        from_axis_next    = 1'b0;

        case (op_reg)
            jeq_pkg::OP_SAMPLE:
            begin
                if (pressed && !btn_down_reg)
                begin
                    btn_down_next    = 1'b1;
                    press_start_next = time_reg;
                    long_fired_next  = 1'b0;
                end
                else if (pressed)
                begin
                    if (!long_fired_reg
                        && ((time_reg - press_start_reg) >= TIME_BITS'(long_reg)))
                    begin
                        long_fired_next = 1'b1;
                        pend_long_next  = 1'b1;
                    end
                end
                else if (btn_down_reg)
                begin
                    btn_down_next = 1'b0;
                    if (!long_fired_reg)
                        pend_short_next = 1'b1;
                end

                if (lock_reg)
                begin
                    if (dir == jeq_pkg::DIR_NONE)
                        lock_next = 1'b0;
                    held_next       = jeq_pkg::DIR_NONE;
                    first_done_next = 1'b0;
                end
                else if (dir != held_reg)
                begin
                    held_next       = dir;
                    dir_start_next  = time_reg;
                    last_rep_next   = time_reg;
                    first_done_next = 1'b0;
                    if (dir != jeq_pkg::DIR_NONE)
                    begin
                        if (!os_locked)
                        begin
                            pend_axis_next  = dir;
                            first_done_next = 1'b1;
                            if (!repeatable)
                            begin
                                last_os_dir_next  = dir;
                                last_os_time_next = time_reg;
                            end
                        end
                    end
                    else
                    begin
                        last_os_dir_next = jeq_pkg::DIR_NONE;
                    end
                end
                else if ((dir != jeq_pkg::DIR_NONE) && first_done_reg && repeatable)
                begin
                    if (((time_reg - dir_start_reg) >= TIME_BITS'(init_dly_reg))
                        && ((time_reg - last_rep_reg) >= TIME_BITS'(repeat_reg)))
                    begin
                        last_rep_next  = time_reg;
                        pend_axis_next = dir;
                    end
                end
            end
            jeq_pkg::OP_LOCK:
            begin
                lock_next       = 1'b1;
                pend_axis_next  = jeq_pkg::EV_NONE;
                held_next       = jeq_pkg::DIR_NONE;
                first_done_next = 1'b0;
            end
            jeq_pkg::OP_TAKE:
            begin
                if (pend_long_reg)
                begin
                    pend_long_next  = 1'b0;
                    event_code_next = jeq_pkg::EV_LONG;
                end
                else if (pend_short_reg)
                begin
                    pend_short_next = 1'b0;
                    event_code_next = jeq_pkg::EV_SHORT;
                end
                else if (pend_axis_reg != jeq_pkg::EV_NONE)
                begin
                    event_code_next = pend_axis_reg;
                    from_axis_next  = 1'b1;
                    pend_axis_next  = jeq_pkg::EV_NONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg   <= jeq_pkg::CENTER_RST;
            dead_reg     <= jeq_pkg::DEAD_RST;
            hyst_reg     <= jeq_pkg::HYST_RST;
            long_reg     <= jeq_pkg::LONG_RST;
            lockout_reg  <= jeq_pkg::LOCKOUT_RST;
            init_dly_reg <= jeq_pkg::INIT_DLY_RST;
            repeat_reg   <= jeq_pkg::REPEAT_RST;
            btn_ign_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jeq_pkg::REG_CENTER:   center_reg   <= cfg_data[jeq_pkg::CENTER_W-1:0];
                jeq_pkg::REG_DEAD:     dead_reg     <= cfg_data[jeq_pkg::DEAD_W-1:0];
                jeq_pkg::REG_HYST:     hyst_reg     <= cfg_data[jeq_pkg::HYST_W-1:0];
                jeq_pkg::REG_LONG:     long_reg     <= cfg_data;
                jeq_pkg::REG_LOCKOUT:  lockout_reg  <= cfg_data;
                jeq_pkg::REG_INIT_DLY: init_dly_reg <= cfg_data;
                jeq_pkg::REG_REPEAT:   repeat_reg   <= cfg_data;
                jeq_pkg::REG_BTN_IGN:  btn_ign_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else if (!sample_stall)
            item_vld_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!sample_stall && sample_valid)
        begin
            op_reg   <= jeq_pkg::op_t'(operation);
            x_reg    <= x_sample;
            y_reg    <= y_sample;
            btn_reg  <= button_level;
            time_reg <= time_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg         <= jeq_pkg::DIR_NONE;
            dir_start_reg    <= '0;
            last_rep_reg     <= '0;
            first_done_reg   <= 1'b0;
            last_os_dir_reg  <= jeq_pkg::DIR_NONE;
            last_os_time_reg <= '0;
            lock_reg         <= 1'b0;
            pend_axis_reg    <= jeq_pkg::EV_NONE;
            btn_down_reg     <= 1'b0;
            press_start_reg  <= '0;
            long_fired_reg   <= 1'b0;
            pend_long_reg    <= 1'b0;
            pend_short_reg   <= 1'b0;
        end
        else if (fire)
        begin
            held_reg         <= held_next;
            dir_start_reg    <= dir_start_next;
            last_rep_reg     <= last_rep_next;
            first_done_reg   <= first_done_next;
            last_os_dir_reg  <= last_os_dir_next;
            last_os_time_reg <= last_os_time_next;
            lock_reg         <= lock_next;
            pend_axis_reg    <= pend_axis_next;
            btn_down_reg     <= btn_down_next;
            press_start_reg  <= press_start_next;
            long_fired_reg   <= long_fired_next;
            pend_long_reg    <= pend_long_next;
            pend_short_reg   <= pend_short_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            event_valid_reg <= 1'b0;
        else if (fire && (op_reg == jeq_pkg::OP_TAKE))
            event_valid_reg <= 1'b1;
        else if (!event_stall)
            event_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && (op_reg == jeq_pkg::OP_TAKE))
        begin
            event_code_reg <= event_code_next;
            from_axis_reg  <= from_axis_next;
        end
    end

    // assertions
    a_take_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (op_reg == jeq_pkg::OP_TAKE)) |=> event_valid)
        else $error("take word produced no result");

    a_axis_code: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && from_axis) |->
            ((event_code == jeq_pkg::DIR_UP) || (event_code == jeq_pkg::DIR_DOWN)
             || (event_code == jeq_pkg::DIR_RIGHT) || (event_code == jeq_pkg::DIR_LEFT)))
        else $error("axis result carries a non-direction code");

    a_lock_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> (held_reg == jeq_pkg::DIR_NONE))
        else $error("direction held while center lock active");

    a_stall_only_take: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (item_vld_reg && (op_reg == jeq_pkg::OP_TAKE)))
        else $error("input stalled without a waiting take word");

endmodule

>>> bench/jeq_checker.sv
// ----------------------------------------------------------------------------
// jeq_checker
// Watches the word, event and register channels of the joystick event
// qualifier, keeps its own copy of the qualifier state and settings, works
// out the event that every take word must return and compares each event
// that leaves the block, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jeq_checker (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       sample_valid,
    input  logic                       sample_stall,
    input  logic [1:0]                 operation,
    input  logic [11:0]                x_sample,
    input  logic [11:0]                y_sample,
    input  logic                       button_level,
    input  logic [31:0]                time_ms,

    input  logic                       event_valid,
    input  logic                       event_stall,
    input  logic [jeq_pkg::CODE_W-1:0] event_code,
    input  logic                       from_axis,

    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [jeq_pkg::IDX_W-1:0]  cfg_index,
    input  logic [jeq_pkg::DATA_W-1:0] cfg_data,

    output int                         mismatch_count,
    output int                         waiting_count,
    output int                         words_seen,
    output int                         axis_events,
    output int                         button_events,
    output int                         empty_takes
);

    typedef struct packed {
        logic [jeq_pkg::CODE_W-1:0] code;
        logic                       axis;
    } event_word_t;

    event_word_t due_events[$];

    logic [jeq_pkg::CENTER_W-1:0] center_q;
    logic [jeq_pkg::DEAD_W-1:0]   dead_q;
    logic [jeq_pkg::HYST_W-1:0]   hyst_q;
    logic [jeq_pkg::MS_W-1:0]     long_q;
    logic [jeq_pkg::MS_W-1:0]     lockout_q;
    logic [jeq_pkg::MS_W-1:0]     init_q;
    logic [jeq_pkg::MS_W-1:0]     repeat_q;
    logic                         ignore_q;

    jeq_pkg::dir_t                held;
    jeq_pkg::dir_t                shot_dir;
    logic [31:0]                  dir_t0;
    logic [31:0]                  rep_t0;
    logic [31:0]                  shot_t;
    logic [31:0]                  press_t0;
    logic                         first_done;
    logic                         lock_on;
    logic [jeq_pkg::CODE_W-1:0]   axis_due;
    logic                         btn_down;
    logic                         long_done;
    logic                         long_due;
    logic                         short_due;

    int mismatches;
    int n_words;
    int n_axis;
    int n_button;
    int n_empty;

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic logic repeatable(input jeq_pkg::dir_t d);
        return (d == jeq_pkg::DIR_UP) || (d == jeq_pkg::DIR_DOWN);
    endfunction

    function automatic jeq_pkg::dir_t read_stick(input logic [11:0] xs,
                                                 input logic [11:0] ys);
        int c, x, y, dz, hy, dx, dy;
        int hold_hi, hold_lo, enter_hi, enter_lo, hi, lo;
        c  = center_q;
        x  = xs;
        y  = ys;
        dz = dead_q;
        hy = hyst_q;
        dx = (x > c) ? x - c : c - x;
        dy = (y > c) ? y - c : c - y;
        hold_hi  = c + dz;
        hold_lo  = c - dz;
        enter_hi = hold_hi + hy;
        enter_lo = hold_lo - hy;
        if (dx > dy)
        begin
            hi = (held == jeq_pkg::DIR_RIGHT) ? hold_hi : enter_hi;
            lo = (held == jeq_pkg::DIR_LEFT) ? hold_lo : enter_lo;
            if (x > hi)
                return jeq_pkg::DIR_RIGHT;
            if (x < lo)
                return jeq_pkg::DIR_LEFT;
        end
        else
        begin
            lo = (held == jeq_pkg::DIR_UP) ? hold_lo : enter_lo;
            hi = (held == jeq_pkg::DIR_DOWN) ? hold_hi : enter_hi;
            if (y < lo)
                return jeq_pkg::DIR_UP;
            if (y > hi)
                return jeq_pkg::DIR_DOWN;
        end
        return jeq_pkg::DIR_NONE;
    endfunction

    task automatic apply_sample(input logic [11:0] xs, input logic [11:0] ys,
                                input logic lvl, input logic [31:0] now);
        logic          pressed;
        jeq_pkg::dir_t d;
        logic [31:0]   elapsed;
        logic [31:0]   since_rep;
        pressed = !lvl && !ignore_q;
        if (pressed && !btn_down)
        begin
            btn_down  = 1'b1;
            press_t0  = now;
            long_done = 1'b0;
        end
        else if (pressed)
        begin
            elapsed = now - press_t0;
            if (!long_done && elapsed >= {16'd0, long_q})
            begin
                long_done = 1'b1;
                long_due  = 1'b1;
            end
        end
        else if (btn_down)
        begin
            btn_down = 1'b0;
            if (!long_done)
                short_due = 1'b1;
        end

        d = read_stick(xs, ys);

        if (lock_on)
        begin
            if (d == jeq_pkg::DIR_NONE)
                lock_on = 1'b0;
            held       = jeq_pkg::DIR_NONE;
            first_done = 1'b0;
        end
        else if (d != held)
        begin
            held       = d;
            dir_t0     = now;
            rep_t0     = now;
            first_done = 1'b0;
            if (d != jeq_pkg::DIR_NONE)
            begin
                elapsed = now - shot_t;
                if (repeatable(d) || d != shot_dir || elapsed >= {16'd0, lockout_q})
                begin
                    axis_due   = d;
                    first_done = 1'b1;
                    if (!repeatable(d))
                    begin
                        shot_dir = d;
                        shot_t   = now;
                    end
                end
            end
            else
                shot_dir = jeq_pkg::DIR_NONE;
        end
        else if (d != jeq_pkg::DIR_NONE && first_done && repeatable(d))
        begin
            elapsed   = now - dir_t0;
            since_rep = now - rep_t0;
            if (elapsed >= {16'd0, init_q} && since_rep >= {16'd0, repeat_q})
            begin
                rep_t0   = now;
                axis_due = d;
            end
        end
    endtask

    function automatic event_word_t take_event();
        event_word_t w;
        w.code = jeq_pkg::EV_NONE;
        w.axis = 1'b0;
        if (long_due)
        begin
            long_due = 1'b0;
            w.code   = jeq_pkg::EV_LONG;
        end
        else if (short_due)
        begin
            short_due = 1'b0;
            w.code    = jeq_pkg::EV_SHORT;
        end
        else if (axis_due != jeq_pkg::EV_NONE)
        begin
            w.code   = axis_due;
            w.axis   = 1'b1;
            axis_due = jeq_pkg::EV_NONE;
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        event_word_t got;
        event_word_t want;
        if (!rst_n)
        begin
            center_q   = jeq_pkg::CENTER_RST;
            dead_q     = jeq_pkg::DEAD_RST;
            hyst_q     = jeq_pkg::HYST_RST;
            long_q     = jeq_pkg::LONG_RST;
            lockout_q  = jeq_pkg::LOCKOUT_RST;
            init_q     = jeq_pkg::INIT_DLY_RST;
            repeat_q   = jeq_pkg::REPEAT_RST;
            ignore_q   = 1'b0;
            held       = jeq_pkg::DIR_NONE;
            shot_dir   = jeq_pkg::DIR_NONE;
            dir_t0     = '0;
            rep_t0     = '0;
            shot_t     = '0;
            press_t0   = '0;
            first_done = 1'b0;
            lock_on    = 1'b0;
            axis_due   = jeq_pkg::EV_NONE;
            btn_down   = 1'b0;
            long_done  = 1'b0;
            long_due   = 1'b0;
            short_due  = 1'b0;
            due_events.delete();
            mismatches = 0;
            n_words    = 0;
            n_axis     = 0;
            n_button   = 0;
            n_empty    = 0;
        end
        else
        begin
            // results leave only after their take has passed the input and result registers, so check them first
            if (event_valid && !event_stall)
            begin
                got.code = event_code;
                got.axis = from_axis;
                if (due_events.size() == 0)
                    report("event with nothing due", got.code, -1);
                else
                begin
                    want = due_events.pop_front();
                    if (got.code !== want.code)
                        report("event_code", got.code, want.code);
                    if (got.axis !== want.axis)
                        report("from_axis", got.axis, want.axis);
                    if (want.axis)
                        n_axis++;
                    else if (want.code != jeq_pkg::EV_NONE)
                        n_button++;
                    else
                        n_empty++;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    jeq_pkg::REG_CENTER:   center_q  = cfg_data[jeq_pkg::CENTER_W-1:0];
                    jeq_pkg::REG_DEAD:     dead_q    = cfg_data[jeq_pkg::DEAD_W-1:0];
                    jeq_pkg::REG_HYST:     hyst_q    = cfg_data[jeq_pkg::HYST_W-1:0];
                    jeq_pkg::REG_LONG:     long_q    = cfg_data[jeq_pkg::MS_W-1:0];
                    jeq_pkg::REG_LOCKOUT:  lockout_q = cfg_data[jeq_pkg::MS_W-1:0];
                    jeq_pkg::REG_INIT_DLY: init_q    = cfg_data[jeq_pkg::MS_W-1:0];
                    jeq_pkg::REG_REPEAT:   repeat_q  = cfg_data[jeq_pkg::MS_W-1:0];
                    jeq_pkg::REG_BTN_IGN:  ignore_q  = cfg_data[0];
                    default: ;
                endcase
            end

            if (sample_valid && !sample_stall)
            begin
                n_words++;
                case (jeq_pkg::op_t'(operation))
                    jeq_pkg::OP_SAMPLE:
                        apply_sample(x_sample, y_sample, button_level, time_ms);
                    jeq_pkg::OP_LOCK:
                    begin
                        lock_on    = 1'b1;
                        axis_due   = jeq_pkg::EV_NONE;
                        held       = jeq_pkg::DIR_NONE;
                        first_done = 1'b0;
                    end
                    jeq_pkg::OP_TAKE:
                        due_events.push_back(take_event());
                    default: ;
                endcase
            end
        end
        mismatch_count <= mismatches;
        waiting_count  <= due_events.size();
        words_seen     <= n_words;
        axis_events    <= n_axis;
        button_events  <= n_button;
        empty_takes    <= n_empty;
    end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the joystick event qualifier with a short directed sequence and then
// with phases of stick gestures, button presses, center locks and takes under
// several register setups, including all-minimum and all-maximum ones. The
// sender idles in bursts, the receiver stalls on its own pattern and, in
// phases 0 and 5, holds off long enough to back the block up. The checker
// beside the block predicts every event and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    localparam logic [31:0] WRAP_BASE = 32'hFFFF_FE00;
    localparam int          PHASES    = 9;
    localparam int          PER_PHASE = 170;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic [1:0]                 operation    = jeq_pkg::OP_SAMPLE;
    logic [11:0]                x_sample     = '0;
    logic [11:0]                y_sample     = '0;
    logic                       button_level = 1'b1;
    logic [31:0]                time_ms      = '0;
    logic                       event_valid;
    logic                       event_stall  = 1'b0;
    logic [jeq_pkg::CODE_W-1:0] event_code;
    logic                       from_axis;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [jeq_pkg::IDX_W-1:0]  cfg_index    = jeq_pkg::REG_CENTER;
    logic [jeq_pkg::DATA_W-1:0] cfg_data     = '0;

    int mismatch_count, waiting_count, words_seen;
    int axis_events, button_events, empty_takes;

    int       burst_left  = 0;
    int       hold_req    = 0;
    int       hold_seen   = 0;
    int       hold_left   = 0;
    int       hold_total  = 0;
    rx_mode_t rx_mode     = RX_FREE;
    int       rx_left     = 0;

    jeq_pkg::dir_t aim      = jeq_pkg::DIR_NONE;
    int            aim_left = 0;
    logic          btn_held = 1'b0;
    int            btn_left = 0;
    logic [31:0]   now      = '0;
    int            tstep    = 100;
    int            setups   = 0;

    int cur_center  = 2048;
    int cur_dead    = 500;
    int cur_hyst    = 150;
    int cur_long    = 1000;
    int cur_lockout = 300;
    int cur_init    = 500;
    int cur_repeat  = 150;
    int cur_ignore  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    joystick_event_qualifier #(
        .SAMPLE_BITS (12),
        .TIME_BITS   (32)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .operation    (operation),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .button_level (button_level),
        .time_ms      (time_ms),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_code   (event_code),
        .from_axis    (from_axis),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    jeq_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .operation      (operation),
        .x_sample       (x_sample),
        .y_sample       (y_sample),
        .button_level   (button_level),
        .time_ms        (time_ms),
        .event_valid    (event_valid),
        .event_stall    (event_stall),
        .event_code     (event_code),
        .from_axis      (from_axis),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .waiting_count  (waiting_count),
        .words_seen     (words_seen),
        .axis_events    (axis_events),
        .button_events  (button_events),
        .empty_takes    (empty_takes)
    );

    // event receiver: own stall pattern plus one long hold-off on request
    always @(posedge clk)
    begin : rx_side
        logic want_stall;
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = 300;
        end
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:  want_stall = 1'b0;
            RX_LIGHT: want_stall = ($urandom_range(0, 3) == 0);
            RX_HEAVY: want_stall = ($urandom_range(0, 3) != 0);
            default:  want_stall = ~event_stall;
        endcase
        if (hold_left > 0)
        begin
            want_stall = 1'b1;
            hold_left--;
            hold_total++;
        end
        event_stall <= want_stall;
    end

    task automatic send_word(input jeq_pkg::op_t op, input logic [11:0] xs,
                             input logic [11:0] ys, input logic lvl,
                             input logic [31:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_valid <= 1'b1;
        operation    <= op;
        x_sample     <= xs;
        y_sample     <= ys;
        button_level <= lvl;
        time_ms      <= t;
        do @(posedge clk); while (sample_stall);
    endtask

    task automatic write_reg(input logic [jeq_pkg::IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[jeq_pkg::DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_setup();
        write_reg(jeq_pkg::REG_CENTER, cur_center);
        write_reg(jeq_pkg::REG_DEAD, cur_dead);
        write_reg(jeq_pkg::REG_HYST, cur_hyst);
        write_reg(jeq_pkg::REG_LONG, cur_long);
        write_reg(jeq_pkg::REG_LOCKOUT, cur_lockout);
        write_reg(jeq_pkg::REG_INIT_DLY, cur_init);
        write_reg(jeq_pkg::REG_REPEAT, cur_repeat);
        write_reg(jeq_pkg::REG_BTN_IGN, cur_ignore);
        cfg_valid <= 1'b0;
        setups++;
    endtask

    // wait out all due events plus the pipeline of the last words
    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (waiting_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [11:0] clip(input int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'hFFF;
        return v[11:0];
    endfunction

    task automatic choose_setup(input int phase);
        case (phase)
            0:
            begin
                cur_center = 2048; cur_dead = 500; cur_hyst = 150; cur_long = 1000;
                cur_lockout = 300; cur_init = 500; cur_repeat = 150; cur_ignore = 0;
            end
            1:
            begin
                cur_center = 0; cur_dead = 0; cur_hyst = 0; cur_long = 0;
                cur_lockout = 0; cur_init = 0; cur_repeat = 0; cur_ignore = 0;
            end
            2:
            begin
                cur_center = 4095; cur_dead = 2047; cur_hyst = 1023; cur_long = 65535;
                cur_lockout = 65535; cur_init = 65535; cur_repeat = 65535; cur_ignore = 1;
            end
            4:
            begin
                cur_center = $urandom_range(1800, 2300); cur_dead = $urandom_range(0, 600);
                cur_hyst = $urandom_range(0, 200); cur_long = 0; cur_lockout = 0;
                cur_init = 0; cur_repeat = 0; cur_ignore = 0;
            end
            default:
            begin
                cur_center  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                          : $urandom_range(1400, 2700);
                cur_dead    = $urandom_range(0, 900);
                cur_hyst    = $urandom_range(0, 300);
                cur_long    = $urandom_range(1, 2000);
                cur_lockout = $urandom_range(0, 600);
                cur_init    = $urandom_range(0, 800);
                cur_repeat  = $urandom_range(1, 300);
                cur_ignore  = (phase == 3 || $urandom_range(0, 9) == 0) ? 1 : 0;
            end
        endcase
        tstep = (cur_init + cur_repeat + cur_long) / 8 + 2;
    endtask

    // one stick/button sample following the current gesture
    task automatic gesture_sample();
        int          off, side, r;
        logic [11:0] xs, ys;
        logic        lvl;
        if (aim_left == 0)
        begin
            aim      = jeq_pkg::dir_t'($urandom_range(0, 4));
            aim_left = $urandom_range(1, 14);
        end
        aim_left--;
        if (btn_left == 0)
        begin
            btn_held = ~btn_held;
            btn_left = $urandom_range(1, 20);
        end
        btn_left--;

        r = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
            0:       off = 4095;
            1:       off = cur_dead + cur_hyst + r - 3;
            2:       off = cur_dead + r - 3;
            default: off = $urandom_range(0, 2600);
        endcase
        side = $urandom_range(0, off / 2 + 1);
        side = ($urandom_range(0, 1) == 0) ? side : -side;
        xs = clip(cur_center + side);
        ys = clip(cur_center + side);
        case (aim)
            jeq_pkg::DIR_UP:    ys = clip(cur_center - off);
            jeq_pkg::DIR_DOWN:  ys = clip(cur_center + off);
            jeq_pkg::DIR_RIGHT: xs = clip(cur_center + off);
            jeq_pkg::DIR_LEFT:  xs = clip(cur_center - off);
            default:
            begin
                r  = $urandom_range(0, 2 * cur_dead);
                xs = clip(cur_center + r - cur_dead);
                r  = $urandom_range(0, 2 * cur_dead);
                ys = clip(cur_center + r - cur_dead);
            end
        endcase
        lvl = ~btn_held;
        if ($urandom_range(0, 29) == 0)
            lvl = ~lvl;
        if ($urandom_range(0, 99) == 0)
            now = $urandom();
        else
            now = now + $urandom_range(0, tstep);
        send_word(jeq_pkg::OP_SAMPLE, xs, ys, lvl, now);
    endtask

    task automatic run_items(input int quota, input logic push_back);
        int n, pick;
        n = 0;
        while (n < quota)
        begin
            if (push_back && n == 10)
                hold_req <= hold_req + 1;
            pick = $urandom_range(0, 99);
            if (pick < 58)
                gesture_sample();
            else if (pick < 85)
                send_word(jeq_pkg::OP_TAKE, 12'($urandom()), 12'($urandom()),
                          1'($urandom()), $urandom());
            else if (pick < 92)
                send_word(jeq_pkg::OP_LOCK, 12'($urandom()), 12'($urandom()),
                          1'($urandom()), $urandom());
            else if (pick < 96)
            begin
                now = now + $urandom_range(0, tstep);
                send_word(jeq_pkg::OP_SAMPLE, 12'($urandom()), 12'($urandom()),
                          1'($urandom()), now);
            end
            else
            begin
                send_word(jeq_pkg::OP_NOP, 12'($urandom()), 12'($urandom()),
                          1'($urandom()), $urandom());
                n--;
            end
            n++;
        end
    endtask

    task automatic directed_run();
        send_word(jeq_pkg::OP_TAKE,   12'hFFF, 12'hFFF, 1'b1, 32'hFFFF_FFFF);
        send_word(jeq_pkg::OP_NOP,    12'h000, 12'h000, 1'b0, 32'h0000_0000);
        send_word(jeq_pkg::OP_SAMPLE, 12'd4095, 12'd2048, 1'b1, WRAP_BASE);
        send_word(jeq_pkg::OP_SAMPLE, 12'd2048, 12'd0,    1'b1, WRAP_BASE + 32'd20);
        // right again inside the lockout window: must stay silent
        send_word(jeq_pkg::OP_SAMPLE, 12'd4095, 12'd2048, 1'b1, WRAP_BASE + 32'd40);
        send_word(jeq_pkg::OP_TAKE,   12'h000, 12'h000, 1'b0, 32'h0000_0000);
        send_word(jeq_pkg::OP_SAMPLE, 12'd0,    12'd2048, 1'b0, WRAP_BASE + 32'd100);
        send_word(jeq_pkg::OP_TAKE,   12'hFFF, 12'h000, 1'b1, 32'hFFFF_FFFF);
        // timestamps cross the 32-bit wrap from here on
        send_word(jeq_pkg::OP_SAMPLE, 12'd2048, 12'd0,    1'b0, WRAP_BASE + 32'd768);
        send_word(jeq_pkg::OP_SAMPLE, 12'd2048, 12'd0,    1'b0, WRAP_BASE + 32'd1200);
        send_word(jeq_pkg::OP_SAMPLE, 12'd2048, 12'd0,    1'b0, WRAP_BASE + 32'd1300);
        send_word(jeq_pkg::OP_TAKE,   12'h000, 12'hFFF, 1'b0, 32'h0000_0000);
        send_word(jeq_pkg::OP_TAKE,   12'h000, 12'h000, 1'b1, 32'h0000_0000);
        // equal deflection on both axes: vertical wins
        send_word(jeq_pkg::OP_SAMPLE, 12'd4000, 12'd96,   1'b1, WRAP_BASE + 32'd1400);
        send_word(jeq_pkg::OP_SAMPLE, 12'd2048, 12'd4095, 1'b0, WRAP_BASE + 32'd1500);
        send_word(jeq_pkg::OP_LOCK,   12'hFFF, 12'h000, 1'b0, 32'hFFFF_FFFF);
        send_word(jeq_pkg::OP_SAMPLE, 12'd2048, 12'd4095, 1'b1, WRAP_BASE + 32'd1600);
        send_word(jeq_pkg::OP_TAKE,   12'h000, 12'h000, 1'b1, 32'h0000_0000);
        send_word(jeq_pkg::OP_SAMPLE, 12'd2048, 12'd2048, 1'b1, WRAP_BASE + 32'd1700);
        send_word(jeq_pkg::OP_SAMPLE, 12'd2048, 12'd4095, 1'b1, WRAP_BASE + 32'd1800);
        send_word(jeq_pkg::OP_TAKE,   12'h000, 12'h000, 1'b1, 32'h0000_0000);
        send_word(jeq_pkg::OP_TAKE,   12'hFFF, 12'hFFF, 1'b0, 32'hFFFF_FFFF);
        now = WRAP_BASE + 32'd2000;
    endtask

    initial
    begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_run();
        settle();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            choose_setup(phase);
            load_setup();
            run_items(PER_PHASE, phase == 0 || phase == 5);
            settle();
        end
        repeat (8) @(posedge clk);
        $display("covered %0d words over %0d register setups; %0d axis, %0d button, %0d empty",
                 words_seen, setups, axis_events, button_events, empty_takes);
        $display("receiver held off %0d cycles in long stretches while words kept coming",
                 hold_total);
        if (mismatch_count == 0 && waiting_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
